// ----- hdl/bplru_pkg.sv -----
// ----------------------------------------------------------------------------
// bplru_pkg
// Shared request codes, status codes and control types of the buffer pool
// frame manager.
// ----------------------------------------------------------------------------
package bplru_pkg;

  // default sizing
  localparam int POOL_FRAMES_DEF  = 16;
  localparam int PAGE_ID_BITS_DEF = 32;
  localparam int PIN_BITS_DEF     = 8;

  // fixed widths of the stream fields
  localparam int PAGE_FIELD_BITS  = 32;
  localparam int COUNT_BITS       = 32;
  localparam int IN_DATA_BITS     = 40;

  // request codes
  typedef enum logic [1:0] {
    FUNC_FETCH = 2'd0,
    FUNC_NEW   = 2'd1,
    FUNC_UNPIN = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_ALL_PINNED   = 2'd1,
    STAT_NOT_RESIDENT = 2'd2,
    STAT_RESIDENT     = 2'd3
  } status_t;

  // recency list commands, at most one per cycle
  typedef struct packed {
    logic push;
    logic drop;
    logic pop;
  } lru_cmd_t;

endpackage

// ----- hdl/buffer_pool_lru_frame_manager_core.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_lru_frame_manager_core
// Frame metadata manager of a page buffer pool: lookup, allocation from the
// free stack or by LRU eviction, unpin and flush, with hit and miss counts.
//
//   channel  dir  tdata                                   side bands
//   s_axis   in   page_id, dirty                          tuser = func
//   m_axis   out  frame, hit, status, read_request,       tlast = last
//                 writeback_valid, writeback_page_id,
//                 sync, hit_count, miss_count
//
// The frame table sits in one single-port-read memory; every lookup step is
// one read plus one compare, over the frames in order from frame 0.
// fetch/new/unpin: the scan ends at the first hit or after the last frame; a
// miss that takes a frame takes it from the free stack or, when that is
// empty, reads an LRU victim back first; the next request is taken in idle.
// flush: scans every frame, one result per dirty frame, then a sync result.
// rst is synchronous and clears used marks, counts and handshakes.
// A stalled result holds the engine in its emit step until taken.
// ----------------------------------------------------------------------------
module buffer_pool_lru_frame_manager_core
  import bplru_pkg::*;
#(
  parameter int POOL_FRAMES  = POOL_FRAMES_DEF,
  parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
  parameter int PIN_BITS     = PIN_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // page_id[31:0], dirty[32], zero pad
  input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // frame, hit, status, read_request, writeback_valid, writeback_page_id,
  // sync, hit_count, miss_count, zero pad
  output logic [((((POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1) + 102 + 7) / 8) * 8 - 1:0]
                                  m_axis_tdata,
  output logic                    m_axis_tlast
);

  localparam int FW       = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CW       = $clog2(POOL_FRAMES + 1);
  localparam int PW       = PAGE_ID_BITS;
  localparam int MW       = PW + PIN_BITS + 1;
  localparam int OUT_BITS = FW + 102;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
  localparam logic [FW-1:0]       LAST_FRAME = FW'(POOL_FRAMES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_L_RD, S_L_EV, S_HIT, S_MISS, S_V_RD, S_V_EV,
    S_INSTALL, S_F_RD, S_F_EV, S_F_NEXT, S_EMIT
  } state_t;

  state_t state;

  // frame table: {page, pin, dirty}
  logic [MW-1:0] mem [POOL_FRAMES];
  logic [MW-1:0] rd_data;
  logic          mem_re;
  logic [FW-1:0] mem_raddr;
  logic          mem_we;
  logic [FW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic [PW-1:0]       rd_page;
  logic [PIN_BITS-1:0] rd_pin;
  logic                rd_dirty;

  // request and working registers
  func_t               req_func;
  logic [PW-1:0]       req_pid;
  logic                req_dirty;
  logic [FW-1:0]       idx;
  logic [FW-1:0]       cur;
  logic [PIN_BITS-1:0] e_pin;
  logic                e_dirty;
  logic [POOL_FRAMES-1:0] used;
  logic [CW-1:0]       free_count;
  logic [COUNT_BITS-1:0] hits;
  logic [COUNT_BITS-1:0] misses;

  // pending result
  logic [FW-1:0]              res_frame;
  logic                       res_hit;
  status_t                    res_status;
  logic                       res_rd;
  logic                       res_wbv;
  logic [PAGE_FIELD_BITS-1:0] res_wbp;
  logic                       res_sync;
  logic                       res_last;

  // recency list
  lru_cmd_t      lru_cmd;
  logic [FW-1:0] lru_frame;
  logic [FW-1:0] lru_head;
  logic [CW-1:0] lru_count;

  logic [PW+PAGE_FIELD_BITS-1:0] pid_wide;
  logic [PW+PAGE_FIELD_BITS-1:0] page_wide;
  logic [PW-1:0]                 in_pid;
  logic [PAGE_FIELD_BITS-1:0]    rd_page_out;
  logic [OUT_W-1:0]              out_pack;
  logic                          accept;
  logic                          out_free;
  logic                          hit_match;
  logic [PIN_BITS-1:0]           hit_pin;
  logic                          hit_dirty;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // page id resized to the stored width and back to the field width
  assign pid_wide    = {{PW{1'b0}}, s_axis_tdata[PAGE_FIELD_BITS-1:0]};
  assign in_pid      = pid_wide[PW-1:0];
  assign page_wide   = {{PAGE_FIELD_BITS{1'b0}}, rd_page};
  assign rd_page_out = page_wide[PAGE_FIELD_BITS-1:0];

  assign rd_page  = rd_data[MW-1 -: PW];
  assign rd_pin   = rd_data[1 +: PIN_BITS];
  assign rd_dirty = rd_data[0];

  assign hit_match = used[idx] && (rd_page == req_pid);

  // updated pin and dirty mark of a resident frame
  always_comb begin
    hit_pin   = e_pin;
    hit_dirty = e_dirty;
    case (req_func)
      FUNC_FETCH: begin
        if (e_pin != PIN_MAX) hit_pin = e_pin + PIN_BITS'(1);
      end
      FUNC_UNPIN: begin
        hit_dirty = e_dirty | req_dirty;
        if (e_pin != '0) hit_pin = e_pin - PIN_BITS'(1);
      end
      default: begin
        hit_pin = e_pin;
      end
    endcase
  end

  // memory and list control decoded from the state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx;
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = {req_pid, PIN_BITS'(1), (req_func == FUNC_NEW)};
    lru_cmd   = '0;
    lru_frame = cur;
    case (state)
      S_L_RD, S_F_RD: begin
        mem_re = 1'b1;
      end
      S_V_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur;
      end
      S_HIT: begin
        mem_we    = (req_func != FUNC_NEW);
        mem_wdata = {req_pid, hit_pin, hit_dirty};
        lru_cmd.drop = (req_func == FUNC_FETCH) && (e_pin == '0);
        lru_cmd.push = (req_func == FUNC_UNPIN) && (e_pin == PIN_BITS'(1));
      end
      S_MISS: begin
        lru_cmd.pop = (req_func != FUNC_UNPIN) && (free_count == '0) &&
                      (lru_count != '0);
      end
      S_INSTALL: begin
        mem_we = 1'b1;
      end
      S_F_EV: begin
        mem_we    = used[idx] && rd_dirty;
        mem_waddr = idx;
        mem_wdata = {rd_page, rd_pin, 1'b0};
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // frame table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  bplru_lru_list #(
    .POOL_FRAMES(POOL_FRAMES)
  ) u_lru (
    .clk     (clk),
    .rst     (rst),
    .cmd     (lru_cmd),
    .frame_in(lru_frame),
    .head    (lru_head),
    .count   (lru_count)
  );

  // result packing, frame in the lowest bits
  always_comb begin
    out_pack = '0;
    out_pack[OUT_BITS-1:0] = {misses, hits, res_sync, res_wbp, res_wbv, res_rd,
                              res_status, res_hit, res_frame};
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      free_count    <= CW'(POOL_FRAMES);
      hits          <= '0;
      misses        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && (state != S_EMIT)) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_func   <= func_t'(s_axis_tuser);
            req_pid    <= in_pid;
            req_dirty  <= s_axis_tdata[PAGE_FIELD_BITS];
            idx        <= '0;
            res_frame  <= '0;
            res_hit    <= 1'b0;
            res_status <= STAT_OK;
            res_rd     <= 1'b0;
            res_wbv    <= 1'b0;
            res_wbp    <= '0;
            res_sync   <= 1'b0;
            res_last   <= 1'b1;
            state <= (func_t'(s_axis_tuser) == FUNC_FLUSH) ? S_F_RD : S_L_RD;
          end
        end
        S_L_RD: begin
          state <= S_L_EV;
        end
        S_L_EV: begin
          if (hit_match) begin
            cur     <= idx;
            e_pin   <= rd_pin;
            e_dirty <= rd_dirty;
            state   <= S_HIT;
          end else if (idx == LAST_FRAME) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + FW'(1);
            state <= S_L_RD;
          end
        end
        S_HIT: begin
          res_frame <= cur;
          case (req_func)
            FUNC_FETCH: begin
              hits    <= hits + COUNT_BITS'(1);
              res_hit <= 1'b1;
            end
            FUNC_NEW: begin
              res_status <= STAT_RESIDENT;
            end
            default: begin
              res_hit <= 1'b0;
            end
          endcase
          state <= S_EMIT;
        end
        S_MISS: begin
          if (req_func == FUNC_UNPIN) begin
            res_status <= STAT_NOT_RESIDENT;
            state      <= S_EMIT;
          end else begin
            if (req_func == FUNC_FETCH) misses <= misses + COUNT_BITS'(1);
            if (free_count != '0) begin
              cur        <= FW'(free_count - CW'(1));
              free_count <= free_count - CW'(1);
              state      <= S_INSTALL;
            end else if (lru_count == '0) begin
              res_status <= STAT_ALL_PINNED;
              state      <= S_EMIT;
            end else begin
              cur            <= lru_head;
              used[lru_head] <= 1'b0;
              state          <= S_V_RD;
            end
          end
        end
        S_V_RD: begin
          state <= S_V_EV;
        end
        S_V_EV: begin
          res_wbv <= rd_dirty;
          res_wbp <= rd_dirty ? rd_page_out : '0;
          state   <= S_INSTALL;
        end
        S_INSTALL: begin
          used[cur] <= 1'b1;
          res_frame <= cur;
          res_rd    <= 1'b1;
          state     <= S_EMIT;
        end
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          if (used[idx] && rd_dirty) begin
            res_frame <= idx;
            res_wbv   <= 1'b1;
            res_wbp   <= rd_page_out;
            res_sync  <= 1'b0;
            res_last  <= 1'b0;
            state     <= S_EMIT;
          end else begin
            state <= S_F_NEXT;
          end
        end
        S_F_NEXT: begin
          if (idx == LAST_FRAME) begin
            res_frame <= '0;
            res_wbv   <= 1'b0;
            res_wbp   <= '0;
            res_sync  <= 1'b1;
            res_last  <= 1'b1;
            state     <= S_EMIT;
          end else begin
            idx   <= idx + FW'(1);
            state <= S_F_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= out_pack;
            m_axis_tlast  <= res_last;
            state         <= res_last ? S_IDLE : S_F_NEXT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the free stack never holds more than the pool
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(POOL_FRAMES))
    else $error("free count above pool size");

  // the recency list never holds more than the pool
  a_lru_bound: assert property (@(posedge clk) disable iff (rst)
    lru_count <= CW'(POOL_FRAMES))
    else $error("lru count above pool size");

  // a frame is installed only when it is not in use
  a_install_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSTALL) |-> !used[cur])
    else $error("install into a used frame");

  // a request is taken only after its last result has been queued
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_L_RD) || (state == S_F_RD))
    else $error("request taken outside idle");
`endif

endmodule

// ----- hdl/bplru_lru_list.sv -----
// ----------------------------------------------------------------------------
// bplru_lru_list
// Recency list of unpinned resident frames: oldest at the head, pushes at
// the tail, removal of any member closes the gap.
// ----------------------------------------------------------------------------
module bplru_lru_list
  import bplru_pkg::*;
#(
  parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  lru_cmd_t                                     cmd,
  input  logic [((POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1)-1:0] frame_in,
  output logic [((POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1)-1:0] head,
  output logic [$clog2(POOL_FRAMES + 1)-1:0]           count
);

  localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CW = $clog2(POOL_FRAMES + 1);

  logic [FW-1:0]          order [POOL_FRAMES];
  logic [CW-1:0]          cnt;
  logic [POOL_FRAMES-1:0] match;
  logic [POOL_FRAMES-1:0] shift;
  logic                   found;
  logic                   has_room;

  // locate the member to drop and mark the entries that move up
  always_comb begin
    logic run;
    run = 1'b0;
    for (int j = 0; j < POOL_FRAMES; j++) begin
      match[j] = (CW'(j) < cnt) && (order[j] == frame_in);
      run      = run | match[j];
      shift[j] = (cmd.pop && (cnt != '0)) || (cmd.drop && run);
    end
    found = run;
  end

  assign has_room = (cnt < CW'(POOL_FRAMES));

  // list entries
  always_ff @(posedge clk) begin
    for (int j = 0; j < POOL_FRAMES - 1; j++) begin
      if (shift[j]) begin
        order[j] <= order[j + 1];
      end
    end
    if (cmd.push && has_room) begin
      order[cnt[FW-1:0]] <= frame_in;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.pop && (cnt != '0)) begin
      cnt <= cnt - CW'(1);
    end else if (cmd.drop && found) begin
      cnt <= cnt - CW'(1);
    end else if (cmd.push && has_room) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign head  = order[0];
  assign count = cnt;

endmodule

// ----- dv/bplru_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bplru_checker
// Watches both stream channels of the buffer pool frame manager, predicts the
// results of every accepted request from its own copy of the frame table and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bplru_checker
  import bplru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           errors,
  output int           pending
);

  localparam int NF = 16;

  typedef struct packed {
    logic [3:0]  frame;
    logic        hit;
    status_t     status;
    logic        rd;
    logic        wbv;
    logic [31:0] wbp;
    logic        sync;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
  } pool_result_t;

  // model of the frame table
  logic [31:0] page_of [NF];
  logic        used    [NF];
  logic [7:0]  pins    [NF];
  logic        dirty_q [NF];
  logic [3:0]  free_stk [NF];
  int          free_cnt;
  logic [3:0]  recency [NF];
  int          rec_cnt;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;

  // ring of expected results, oldest at rd_ptr
  pool_result_t result_ring [64];
  int           wr_ptr;
  int           rd_ptr;

  assign pending = wr_ptr - rd_ptr;

  task automatic clear_pool();
    for (int i = 0; i < NF; i++) begin
      page_of[i] = '0;
      used[i] = 1'b0;
      pins[i] = '0;
      dirty_q[i] = 1'b0;
      free_stk[i] = i[3:0];
      recency[i] = '0;
    end
    free_cnt = NF;
    rec_cnt = 0;
    hit_cnt = '0;
    miss_cnt = '0;
  endtask

  task automatic queue_result(pool_result_t r);
    result_ring[wr_ptr[5:0]] = r;
    wr_ptr++;
  endtask

  function automatic int find_page(logic [31:0] pid);
    for (int i = 0; i < NF; i++)
      if (used[i] && page_of[i] == pid) return i;
    return -1;
  endfunction

  // remove entry at position p of the recency list
  task automatic recency_remove(int p);
    for (int j = p + 1; j < rec_cnt; j++) recency[j-1] = recency[j];
    rec_cnt--;
  endtask

  // free stack first, else evict least recent unpinned frame
  task automatic grab_frame(output int f, output logic wbv, output logic [31:0] wbp);
    wbv = 1'b0;
    wbp = '0;
    if (free_cnt > 0) begin
      free_cnt--;
      f = free_stk[free_cnt];
    end else if (rec_cnt == 0) begin
      f = -1;
    end else begin
      f = recency[0];
      recency_remove(0);
      if (dirty_q[f]) begin
        wbv = 1'b1;
        wbp = page_of[f];
        dirty_q[f] = 1'b0;
      end
      used[f] = 1'b0;
    end
  endtask

  function automatic pool_result_t mk(int f, logic hit, status_t st, logic rd, logic wbv,
                                      logic [31:0] wbp, logic sync, logic last);
    pool_result_t r;
    r.frame = f[3:0];
    r.hit = hit;
    r.status = st;
    r.rd = rd;
    r.wbv = wbv;
    r.wbp = wbp;
    r.sync = sync;
    r.last = last;
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  task automatic predict_request(func_t fn, logic [31:0] pid, logic dflag);
    int          f;
    logic        wbv;
    logic [31:0] wbp;
    f = find_page(pid);
    case (fn)
      FUNC_FETCH, FUNC_NEW: begin
        if (fn == FUNC_FETCH && f >= 0) begin
          hit_cnt++;
          if (pins[f] == 0)
            for (int i = 0; i < rec_cnt; i++)
              if (recency[i] == f[3:0]) begin
                recency_remove(i);
                break;
              end
          if (pins[f] != 8'hFF) pins[f]++;
          queue_result(mk(f, 1'b1, STAT_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else if (f >= 0) begin
          queue_result(mk(f, 1'b0, STAT_RESIDENT, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else begin
          if (fn == FUNC_FETCH) miss_cnt++;
          grab_frame(f, wbv, wbp);
          if (f < 0) begin
            queue_result(mk(0, 1'b0, STAT_ALL_PINNED, 1'b0, 1'b0, '0, 1'b0, 1'b1));
          end else begin
            page_of[f] = pid;
            used[f] = 1'b1;
            pins[f] = 8'd1;
            dirty_q[f] = (fn == FUNC_NEW);
            queue_result(mk(f, 1'b0, STAT_OK, 1'b1, wbv, wbp, 1'b0, 1'b1));
          end
        end
      end
      FUNC_UNPIN: begin
        if (f < 0) begin
          queue_result(mk(0, 1'b0, STAT_NOT_RESIDENT, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else begin
          if (dflag) dirty_q[f] = 1'b1;
          if (pins[f] > 0) begin
            pins[f]--;
            if (pins[f] == 0 && rec_cnt < NF) begin
              recency[rec_cnt] = f[3:0];
              rec_cnt++;
            end
          end
          queue_result(mk(f, 1'b0, STAT_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < NF; i++)
          if (used[i] && dirty_q[i]) begin
            queue_result(mk(i, 1'b0, STAT_OK, 1'b0, 1'b1, page_of[i], 1'b0, 1'b0));
            dirty_q[i] = 1'b0;
          end
        queue_result(mk(0, 1'b0, STAT_OK, 1'b0, 1'b0, '0, 1'b1, 1'b1));
      end
    endcase
  endtask

  // predict on request transactions, compare on result transactions
  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      clear_pool();
      wr_ptr = 0;
      rd_ptr = 0;
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_request(func_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[32]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.frame  = m_axis_tdata[3:0];
        got.hit    = m_axis_tdata[4];
        got.status = status_t'(m_axis_tdata[6:5]);
        got.rd     = m_axis_tdata[7];
        got.wbv    = m_axis_tdata[8];
        got.wbp    = m_axis_tdata[40:9];
        got.sync   = m_axis_tdata[41];
        got.hits   = m_axis_tdata[73:42];
        got.misses = m_axis_tdata[105:74];
        got.last   = m_axis_tlast;
        if (wr_ptr == rd_ptr) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = result_ring[rd_ptr[5:0]];
          rd_ptr++;
          if (got.frame !== want.frame || got.hit !== want.hit ||
              got.status !== want.status || got.rd !== want.rd ||
              got.wbv !== want.wbv || got.wbp !== want.wbp ||
              got.sync !== want.sync || got.last !== want.last ||
              got.hits !== want.hits || got.misses !== want.misses ||
              m_axis_tdata[111:106] !== '0) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives fetch, new page, unpin and flush requests into the frame manager,
// directed corner cases first and then random traffic over a small page set
// so that hits, evictions and writebacks are frequent. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
  import bplru_pkg::*;
();

  localparam int WATCH_LIMIT = 4000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           errors;
  int           pending;
  logic         gaps;
  int           quiet_cycles;
  logic [31:0]  page_set [24];

  buffer_pool_lru_frame_manager_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  bplru_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk)
    m_axis_tready <= gaps ? ($urandom_range(99) >= 23) : 1'b1;

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one request transaction, with an occasional idle gap after it
  task automatic send_request(func_t fn, logic [31:0] pid, logic dflag);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {7'd0, dflag, pid};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    if (gaps && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    int    pick;
    func_t fn;
    rst = 1'b1;
    gaps = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_FETCH;
    for (int i = 0; i < 24; i++) page_set[i] = $urandom();
    page_set[0] = 32'h0;
    page_set[1] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every request kind, resident and non-resident cases
    send_request(FUNC_UNPIN, 32'h0, 1'b1);
    send_request(FUNC_FLUSH, 32'h0, 1'b0);
    send_request(FUNC_FETCH, 32'h0, 1'b0);
    send_request(FUNC_FETCH, 32'h0, 1'b0);
    send_request(FUNC_NEW, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_NEW, 32'hFFFF_FFFF, 1'b0);
    send_request(FUNC_UNPIN, 32'hFFFF_FFFF, 1'b0);
    send_request(FUNC_UNPIN, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_FETCH, 32'hFFFF_FFFF, 1'b0);
    send_request(FUNC_FLUSH, 32'h0, 1'b1);
    // fill every frame so all are pinned
    for (int i = 2; i < 16; i++) send_request(FUNC_FETCH, page_set[i], 1'b0);
    send_request(FUNC_FETCH, page_set[20], 1'b0);
    send_request(FUNC_NEW, page_set[21], 1'b0);
    // pin count climb on one page, then unpin back down past zero
    for (int i = 0; i < 6; i++) send_request(FUNC_FETCH, 32'h0, 1'b0);
    for (int i = 0; i < 9; i++) send_request(FUNC_UNPIN, 32'h0, i[0]);

    // random traffic, mostly over the page set, with a stretch of no idling
    for (int n = 0; n < 170; n++) begin
      gaps = !(n >= 80 && n < 130);
      pick = $urandom_range(99);
      if (pick < 40)      fn = FUNC_FETCH;
      else if (pick < 58) fn = FUNC_NEW;
      else if (pick < 94) fn = FUNC_UNPIN;
      else                fn = FUNC_FLUSH;
      send_request(fn, ($urandom_range(9) == 0) ? $urandom() : page_set[$urandom_range(23)],
                   1'($urandom_range(1)));
    end
    s_axis_tvalid <= 1'b0;
    gaps = 1'b1;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
